// ===== hw/rtl/sscte_pkg.sv =====
// shared constants, codes and types of the sorted sparse coefficient table
`timescale 1ns / 1ps

package sscte_pkg;

  // list geometry
  localparam int MAX_ORDER = 4;
  localparam int CAPACITY  = 256;
  localparam int DEPTH     = MAX_ORDER * CAPACITY;
  localparam int LIST_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ADDR_W    = $clog2(DEPTH);

  // field widths
  localparam int OP_W  = 2;
  localparam int ORD_W = 4;
  localparam int KEY_W = 32;
  localparam int VAL_W = 64;

  localparam logic [ORD_W-1:0] TRUNC_RESET = ORD_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_GET   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // access request to the key and value memories
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [LIST_W-1:0] list;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [KEY_W-1:0]  wr_key;
    logic [VAL_W-1:0]  wr_val;
  } mem_req_t;

endpackage

// ===== hw/rtl/sscte_req_if.sv =====
// request channel: opcode, order, key and value
`timescale 1ns / 1ps

interface sscte_req_if;
  logic                          valid;
  logic                          ready;
  logic [sscte_pkg::OP_W-1:0]    opcode;
  logic [sscte_pkg::ORD_W-1:0]   order_sel;
  logic [sscte_pkg::KEY_W-1:0]   key_in;
  logic [sscte_pkg::VAL_W-1:0]   value_in;

  modport source (output valid, opcode, order_sel, key_in, value_in, input ready);
  modport sink   (input valid, opcode, order_sel, key_in, value_in, output ready);
endinterface

// ===== hw/rtl/sscte_rsp_if.sv =====
// response channel: value read, found flag and status
`timescale 1ns / 1ps

interface sscte_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sscte_pkg::VAL_W-1:0]   value_out;
  logic                          found;
  logic [1:0]                    status;

  modport source (output valid, value_out, found, status, input ready);
  modport sink   (input valid, value_out, found, status, output ready);
endinterface

// ===== hw/rtl/sscte_store.sv =====
// key and value memories of all sparse lists, one read and one write port
`timescale 1ns / 1ps

module sscte_store (
  input  logic                        clk,
  input  sscte_pkg::mem_req_t         mreq,
  output logic [sscte_pkg::KEY_W-1:0] key_rd,
  output logic [sscte_pkg::VAL_W-1:0] val_rd
);

  logic [sscte_pkg::KEY_W-1:0]  key_mem [sscte_pkg::DEPTH];
  logic [sscte_pkg::VAL_W-1:0]  val_mem [sscte_pkg::DEPTH];
  logic [sscte_pkg::ADDR_W-1:0] list_base;
  logic [sscte_pkg::ADDR_W-1:0] rd_addr;
  logic [sscte_pkg::ADDR_W-1:0] wr_addr;

  // each list owns a block of capacity entries
  assign list_base = sscte_pkg::ADDR_W'(mreq.list) *
                     sscte_pkg::ADDR_W'(sscte_pkg::CAPACITY);
  assign rd_addr   = list_base + sscte_pkg::ADDR_W'(mreq.rd_idx);
  assign wr_addr   = list_base + sscte_pkg::ADDR_W'(mreq.wr_idx);

  // write port
  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      key_mem[wr_addr] <= mreq.wr_key;
      val_mem[wr_addr] <= mreq.wr_val;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (mreq.rd_en) begin
      key_rd <= key_mem[rd_addr];
      val_rd <= val_mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sorted_sparse_coefficient_table_unit.sv =====
// top level: sorted sparse coefficient table with binary search and insert
`timescale 1ns / 1ps

// Holds a 64-bit real part and one sorted (key, value) list per order in a
// key/value memory pair with one read and one write port. One request is
// worked on at a time. Order 0, clear, ignored and unused requests go from
// idle straight to the done state and reach the response register once it
// is free. A get or set of a list of n entries binary-searches with one
// memory read per step, a read in the search state and a compare in the
// compare state. An insert at position p then moves n - p entries up, each
// read and then written one place higher once the data is back, and then
// writes the new entry. The block returns to idle as the response register
// is loaded, and it waits in the done state as long as the previous
// response is still held.
// A new request is taken while the previous response still waits.
// No memory clearing pass is needed: only entries below a list's count are
// ever read, and clear simply zeroes the counts.
module sorted_sparse_coefficient_table_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sscte_pkg::ORD_W-1:0]    cfg_wdata,
  sscte_req_if.sink                      req,
  sscte_rsp_if.source                    rsp
);

  sscte_pkg::state_t   state;
  sscte_pkg::state_t   state_next;
  sscte_pkg::mem_req_t mreq;

  logic [sscte_pkg::ORD_W-1:0]  trunc;
  logic [sscte_pkg::ORD_W-1:0]  limit;
  logic [sscte_pkg::VAL_W-1:0]  real_part;
  logic [sscte_pkg::CNT_W-1:0]  counts [sscte_pkg::MAX_ORDER];

  // latched request
  logic [sscte_pkg::OP_W-1:0]   op;
  logic [sscte_pkg::LIST_W-1:0] list;
  logic [sscte_pkg::KEY_W-1:0]  key;
  logic [sscte_pkg::VAL_W-1:0]  val;

  // search and shift registers
  logic [sscte_pkg::CNT_W-1:0]  cnt;
  logic [sscte_pkg::CNT_W-1:0]  lo;
  logic [sscte_pkg::CNT_W-1:0]  hi;
  logic [sscte_pkg::CNT_W-1:0]  mid;
  logic [sscte_pkg::CNT_W-1:0]  mid_calc;
  logic [sscte_pkg::CNT_W-1:0]  j;

  // memory read data
  logic [sscte_pkg::KEY_W-1:0]  key_rd;
  logic [sscte_pkg::VAL_W-1:0]  val_rd;

  // result and response registers
  logic [sscte_pkg::VAL_W-1:0]  res_val;
  logic                         res_found;
  sscte_pkg::status_t           res_status;
  logic                         out_valid;
  logic [sscte_pkg::VAL_W-1:0]  out_val;
  logic                         out_found;
  sscte_pkg::status_t           out_status;

  logic req_fire;
  logic hit;
  logic out_free;
  logic [sscte_pkg::LIST_W-1:0] req_list;

  assign limit    = (trunc < sscte_pkg::ORD_W'(sscte_pkg::MAX_ORDER)) ?
                    trunc : sscte_pkg::ORD_W'(sscte_pkg::MAX_ORDER);
  assign req_fire = req.valid && req.ready;
  assign req_list = sscte_pkg::LIST_W'(req.order_sel - sscte_pkg::ORD_W'(1));
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign hit      = (lo < cnt) && (key_rd == key);
  assign out_free = !out_valid || rsp.ready;

  assign rsp.valid     = out_valid;
  assign rsp.value_out = out_val;
  assign rsp.found     = out_found;
  assign rsp.status    = out_status;

  sscte_store u_store (
    .clk    (clk),
    .mreq   (mreq),
    .key_rd (key_rd),
    .val_rd (val_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sscte_pkg::S_IDLE: begin
        if (req_fire) begin
          if ((req.opcode == sscte_pkg::OP_GET || req.opcode == sscte_pkg::OP_SET) &&
              req.order_sel != '0 && req.order_sel <= limit) begin
            state_next = sscte_pkg::S_SEARCH;
          end else begin
            state_next = sscte_pkg::S_DONE;
          end
        end
      end
      sscte_pkg::S_SEARCH: begin
        state_next = (lo < hi) ? sscte_pkg::S_CMP : sscte_pkg::S_CHECK;
      end
      sscte_pkg::S_CMP: begin
        state_next = sscte_pkg::S_SEARCH;
      end
      sscte_pkg::S_CHECK: begin
        if (op == sscte_pkg::OP_GET || hit ||
            cnt == sscte_pkg::CNT_W'(sscte_pkg::CAPACITY)) begin
          state_next = sscte_pkg::S_DONE;
        end else begin
          state_next = sscte_pkg::S_SHIFT_RD;
        end
      end
      sscte_pkg::S_SHIFT_RD: begin
        state_next = (j > lo) ? sscte_pkg::S_SHIFT_WR : sscte_pkg::S_DONE;
      end
      sscte_pkg::S_SHIFT_WR: begin
        state_next = sscte_pkg::S_SHIFT_RD;
      end
      sscte_pkg::S_DONE: begin
        if (out_free) begin
          state_next = sscte_pkg::S_IDLE;
        end
      end
      default: state_next = sscte_pkg::S_IDLE;
    endcase
  end

  // memory accesses and request ready
  always_comb begin
    req.ready   = 1'b0;
    mreq.rd_en  = 1'b0;
    mreq.wr_en  = 1'b0;
    mreq.list   = list;
    mreq.rd_idx = mid_calc[sscte_pkg::IDX_W-1:0];
    mreq.wr_idx = lo[sscte_pkg::IDX_W-1:0];
    mreq.wr_key = key;
    mreq.wr_val = val;
    unique case (state)
      sscte_pkg::S_IDLE: begin
        req.ready = 1'b1;
      end
      sscte_pkg::S_SEARCH: begin
        // probe the middle, or the final position to test for a hit
        if (lo < hi) begin
          mreq.rd_en = 1'b1;
        end else begin
          mreq.rd_en  = (lo < cnt);
          mreq.rd_idx = lo[sscte_pkg::IDX_W-1:0];
        end
      end
      sscte_pkg::S_CHECK: begin
        // overwrite an existing entry in place
        mreq.wr_en = (op == sscte_pkg::OP_SET) && hit;
      end
      sscte_pkg::S_SHIFT_RD: begin
        if (j > lo) begin
          mreq.rd_en  = 1'b1;
          mreq.rd_idx = sscte_pkg::IDX_W'(j - sscte_pkg::CNT_W'(1));
        end else begin
          mreq.wr_en = 1'b1;
        end
      end
      sscte_pkg::S_SHIFT_WR: begin
        // move one entry up by one
        mreq.wr_en  = 1'b1;
        mreq.wr_idx = j[sscte_pkg::IDX_W-1:0];
        mreq.wr_key = key_rd;
        mreq.wr_val = val_rd;
      end
      sscte_pkg::S_CMP, sscte_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sscte_pkg::S_IDLE;
      trunc     <= sscte_pkg::TRUNC_RESET;
      real_part <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < sscte_pkg::MAX_ORDER; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        trunc <= cfg_wdata;
      end
      // response register
      if (state == sscte_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      // real part and list counts
      if (state == sscte_pkg::S_IDLE && req_fire) begin
        if (req.opcode == sscte_pkg::OP_CLEAR) begin
          real_part <= req.value_in;
          for (int i = 0; i < sscte_pkg::MAX_ORDER; i++) begin
            counts[i] <= '0;
          end
        end else if (req.opcode == sscte_pkg::OP_SET && req.order_sel == '0) begin
          real_part <= req.value_in;
        end
      end
      if (state == sscte_pkg::S_SHIFT_RD && !(j > lo)) begin
        counts[list] <= cnt + sscte_pkg::CNT_W'(1);
      end
    end
  end

  // request payload, search bounds and result
  always_ff @(posedge clk) begin
    case (state)
      sscte_pkg::S_IDLE: begin
        if (req_fire) begin
          op         <= req.opcode;
          list       <= req_list;
          key        <= req.key_in;
          val        <= req.value_in;
          cnt        <= counts[req_list];
          lo         <= '0;
          hi         <= counts[req_list];
          res_val    <= '0;
          res_found  <= 1'b0;
          res_status <= sscte_pkg::ST_OK;
          if (req.opcode == sscte_pkg::OP_GET || req.opcode == sscte_pkg::OP_SET) begin
            if (req.order_sel == '0) begin
              if (req.opcode == sscte_pkg::OP_GET) begin
                res_val <= real_part;
              end
            end else if (req.order_sel > limit) begin
              res_status <= sscte_pkg::ST_IGNORED;
            end
          end
        end
      end
      sscte_pkg::S_SEARCH: begin
        mid <= mid_calc;
      end
      sscte_pkg::S_CMP: begin
        // lower-bound step
        if (key_rd < key) begin
          lo <= mid + sscte_pkg::CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
      sscte_pkg::S_CHECK: begin
        res_found <= hit;
        j         <= cnt;
        if (op == sscte_pkg::OP_GET) begin
          res_val <= hit ? val_rd : '0;
        end else if (!hit && cnt == sscte_pkg::CNT_W'(sscte_pkg::CAPACITY)) begin
          res_status <= sscte_pkg::ST_FULL;
        end
      end
      sscte_pkg::S_SHIFT_WR: begin
        j <= j - sscte_pkg::CNT_W'(1);
      end
      sscte_pkg::S_DONE: begin
        if (out_free) begin
          out_val    <= res_val;
          out_found  <= res_found;
          out_status <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sim/tb_sorted_sparse_coefficient_table_unit.sv =====
// testbench for the sorted sparse coefficient table: directed and random requests, scoreboarded
`timescale 1ns / 1ps

module tb_sorted_sparse_coefficient_table_unit;

  localparam int                          WATCHDOG_LIMIT = 4000;
  localparam int                          HOLD_CYCLES    = 400;
  localparam int                          DRAIN_CYCLES   = 20;
  localparam logic [sscte_pkg::KEY_W-1:0] FILL_BASE      = 32'h8000_0000;

  typedef struct {
    logic [sscte_pkg::VAL_W-1:0] value;
    logic                        found;
    sscte_pkg::status_t          status;
  } coeff_rsp_t;

  // mirror of the table contents and queue of responses still owed
  class coeff_scoreboard;
    logic [sscte_pkg::ORD_W-1:0] trunc;
    logic [sscte_pkg::VAL_W-1:0] real_part;
    logic [sscte_pkg::KEY_W-1:0] keys [sscte_pkg::MAX_ORDER][sscte_pkg::CAPACITY];
    logic [sscte_pkg::VAL_W-1:0] vals [sscte_pkg::MAX_ORDER][sscte_pkg::CAPACITY];
    int                          count [sscte_pkg::MAX_ORDER];
    coeff_rsp_t                  pending_rsp [$];
    int                          errors = 0;
    int                          n_req = 0;
    int                          n_hit = 0;
    int                          n_full = 0;
    int                          n_ignored = 0;

    function new();
      trunc     = sscte_pkg::TRUNC_RESET;
      real_part = '0;
      foreach (count[i]) count[i] = 0;
    endfunction

    function void report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endfunction

    // work out the response to one accepted request and update the mirror
    function void note_request(sscte_pkg::opcode_t op, logic [sscte_pkg::ORD_W-1:0] ord,
                               logic [sscte_pkg::KEY_W-1:0] key,
                               logic [sscte_pkg::VAL_W-1:0] val);
      coeff_rsp_t r;
      int         limit;
      int         lst;
      int         cnt;
      int         pos;
      bit         hit;
      r.value  = '0;
      r.found  = 1'b0;
      r.status = sscte_pkg::ST_OK;
      limit = (int'(trunc) < sscte_pkg::MAX_ORDER) ? int'(trunc) : sscte_pkg::MAX_ORDER;
      n_req++;
      if (op == sscte_pkg::OP_CLEAR) begin
        real_part = val;
        foreach (count[i]) count[i] = 0;
      end else if (op == sscte_pkg::OP_GET || op == sscte_pkg::OP_SET) begin
        if (ord == '0) begin
          if (op == sscte_pkg::OP_GET) r.value = real_part;
          else real_part = val;
        end else if (int'(ord) > limit) begin
          r.status = sscte_pkg::ST_IGNORED;
          n_ignored++;
        end else begin
          lst = int'(ord) - 1;
          cnt = count[lst];
          // lower bound: first entry whose key is not below the request key
          pos = 0;
          while (pos < cnt && keys[lst][pos] < key) pos++;
          hit = (pos < cnt) && (keys[lst][pos] == key);
          r.found = hit;
          if (hit) n_hit++;
          if (op == sscte_pkg::OP_GET) begin
            if (hit) r.value = vals[lst][pos];
          end else if (hit) begin
            vals[lst][pos] = val;
          end else if (cnt >= sscte_pkg::CAPACITY) begin
            r.status = sscte_pkg::ST_FULL;
            n_full++;
          end else begin
            // open a slot at pos and move the later entries up
            for (int j = cnt; j > pos; j--) begin
              keys[lst][j] = keys[lst][j-1];
              vals[lst][j] = vals[lst][j-1];
            end
            keys[lst][pos] = key;
            vals[lst][pos] = val;
            count[lst]     = cnt + 1;
          end
        end
      end
      pending_rsp.push_back(r);
    endfunction

    // compare one accepted response against the oldest expectation
    function void check_response(logic [sscte_pkg::VAL_W-1:0] v, logic f, logic [1:0] s);
      coeff_rsp_t e;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response with nothing outstanding: value %h", v));
        return;
      end
      e = pending_rsp.pop_front();
      if (v !== e.value) report($sformatf("value_out %h, expected %h", v, e.value));
      if (f !== e.found) report($sformatf("found %b, expected %b", f, e.found));
      if (s !== e.status) report($sformatf("status %0d, expected %0d", s, e.status));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [sscte_pkg::ORD_W-1:0] cfg_wdata = '0;

  sscte_req_if req_ch ();
  sscte_rsp_if rsp_ch ();

  coeff_scoreboard sb;

  bit quiet = 1'b0;
  bit send_gaps = 1'b1;
  bit stall_on = 1'b1;
  bit hold_pending = 1'b0;
  int stall_count = 0;
  int n_settings = 0;

  sorted_sparse_coefficient_table_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response side: random stalls plus one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pending = 1'b0;
      end else if (!quiet && stall_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      if ($urandom_range(0, 49) == 0) stall_on = !stall_on;
      rsp_ch.ready = 1'b1;
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_response(rsp_ch.value_out, rsp_ch.found, rsp_ch.status);
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_sorted_sparse_coefficient_table_unit: done, errors");
      $finish;
    end
  end

  // offer one request, optionally after a gap; returns at the falling edge after acceptance
  task automatic send_request(sscte_pkg::opcode_t op, logic [sscte_pkg::ORD_W-1:0] ord,
                              logic [sscte_pkg::KEY_W-1:0] key,
                              logic [sscte_pkg::VAL_W-1:0] val);
    if (!quiet && send_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.opcode    = op;
    req_ch.order_sel = ord;
    req_ch.key_in    = key;
    req_ch.value_in  = val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(op, ord, key, val);
    @(negedge clk);
  endtask

  // change the truncation order once the block has gone idle
  task automatic write_truncation(logic [sscte_pkg::ORD_W-1:0] t);
    req_ch.valid = 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = t;
    @(posedge clk);
    sb.trunc = t;
    @(negedge clk);
    cfg_we = 1'b0;
    n_settings++;
  endtask

  // random request with keys mostly from a small pool so that hits are common
  task automatic random_request(logic [sscte_pkg::KEY_W-1:0] key_base);
    int                          lim;
    int                          pick;
    sscte_pkg::opcode_t          op;
    logic [sscte_pkg::ORD_W-1:0] ord;
    logic [sscte_pkg::KEY_W-1:0] key;
    lim  = (int'(sb.trunc) < sscte_pkg::MAX_ORDER) ? int'(sb.trunc) : sscte_pkg::MAX_ORDER;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = sscte_pkg::OP_GET;
    else if (pick < 95) op = sscte_pkg::OP_SET;
    else if (pick < 98) op = sscte_pkg::OP_NONE;
    else op = sscte_pkg::OP_CLEAR;
    if ($urandom_range(0, 9) == 0) ord = sscte_pkg::ORD_W'($urandom_range(0, 15));
    else ord = sscte_pkg::ORD_W'($urandom_range(0, lim));
    if ($urandom_range(0, 7) == 0) key = $urandom;
    else key = key_base + $urandom_range(0, 15);
    if ($urandom_range(0, 39) == 0) send_gaps = !send_gaps;
    send_request(op, ord, key, {$urandom, $urandom});
  endtask

  initial begin
    sb = new();
    req_ch.valid     = 1'b0;
    req_ch.opcode    = sscte_pkg::OP_GET;
    req_ch.order_sel = '0;
    req_ch.key_in    = '0;
    req_ch.value_in  = '0;

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed requests at the reset truncation order
    send_request(sscte_pkg::OP_GET,   4'd0,  32'h0,         64'h0);
    send_request(sscte_pkg::OP_SET,   4'd0,  32'h0,         64'hFFFF_FFFF_FFFF_FFFF);
    send_request(sscte_pkg::OP_GET,   4'd0,  32'h0,         64'h0);
    send_request(sscte_pkg::OP_GET,   4'd1,  32'h0,         64'h0);
    send_request(sscte_pkg::OP_SET,   4'd1,  32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(sscte_pkg::OP_SET,   4'd1,  32'h0,         64'h0123_4567_89AB_CDEF);
    send_request(sscte_pkg::OP_SET,   4'd1,  32'h0,         64'h0);
    send_request(sscte_pkg::OP_SET,   4'd1,  32'h8000_0000, 64'hA5A5_5A5A_A5A5_5A5A);
    send_request(sscte_pkg::OP_GET,   4'd1,  32'hFFFF_FFFF, 64'h0);
    send_request(sscte_pkg::OP_GET,   4'd1,  32'h0,         64'h0);
    send_request(sscte_pkg::OP_GET,   4'd1,  32'h5,         64'h0);
    send_request(sscte_pkg::OP_SET,   4'd2,  32'h1,         64'h8000_0000_0000_0001);
    send_request(sscte_pkg::OP_GET,   4'd2,  32'h1,         64'h0);
    send_request(sscte_pkg::OP_SET,   4'd3,  32'h1,         64'h1);
    send_request(sscte_pkg::OP_GET,   4'd8,  32'h0,         64'h0);
    send_request(sscte_pkg::OP_SET,   4'd15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(sscte_pkg::OP_NONE,  4'd1,  32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(sscte_pkg::OP_CLEAR, 4'd0,  32'h0,         64'h5555_AAAA_5555_AAAA);
    send_request(sscte_pkg::OP_GET,   4'd0,  32'h0,         64'h0);
    send_request(sscte_pkg::OP_GET,   4'd1,  32'hFFFF_FFFF, 64'h0);
    send_request(sscte_pkg::OP_GET,   4'd2,  32'h1,         64'h0);

    // no active lists
    write_truncation(4'd0);
    send_request(sscte_pkg::OP_GET, 4'd1, 32'h0, 64'h0);
    repeat (60) random_request(32'h0);

    // all lists active, keys near the top of the range
    write_truncation(4'd8);
    repeat (150) random_request(32'hFFFF_FFF0);

    // fill one list to capacity, worst-case shifting on every insert
    write_truncation(4'd4);
    send_request(sscte_pkg::OP_CLEAR, 4'd0, 32'h0, {$urandom, $urandom});
    for (int i = sscte_pkg::CAPACITY - 1; i >= 0; i--)
      send_request(sscte_pkg::OP_SET, 4'd3, FILL_BASE + i * 7, {$urandom, $urandom});
    send_request(sscte_pkg::OP_SET, 4'd3, FILL_BASE + 3,  {$urandom, $urandom});
    send_request(sscte_pkg::OP_SET, 4'd3, 32'hFFFF_FFFF,  {$urandom, $urandom});
    send_request(sscte_pkg::OP_SET, 4'd3, FILL_BASE + 14, {$urandom, $urandom});
    send_request(sscte_pkg::OP_GET, 4'd3, FILL_BASE + 14, 64'h0);
    send_request(sscte_pkg::OP_GET, 4'd3, FILL_BASE,      64'h0);
    send_request(sscte_pkg::OP_GET, 4'd3, FILL_BASE + (sscte_pkg::CAPACITY - 1) * 7, 64'h0);
    send_request(sscte_pkg::OP_GET, 4'd3, FILL_BASE + 3,  64'h0);

    // truncation above the list count, full list still in place
    write_truncation(4'd15);
    repeat (100) random_request(FILL_BASE);

    // long response hold-off while requests keep coming
    write_truncation(4'd1);
    send_gaps    = 1'b0;
    hold_pending = 1'b1;
    repeat (100) random_request($urandom);

    // last stretch with no idling on either side
    write_truncation(4'd3);
    quiet = 1'b1;
    repeat (100) random_request(32'h0);

    // drain
    req_ch.valid = 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests over %0d truncation changes, one list filled to capacity",
             sb.n_req, n_settings);
    $display("key hits %0d, full-list drops %0d, out-of-range orders %0d, mismatches %0d",
             sb.n_hit, sb.n_full, sb.n_ignored, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_sorted_sparse_coefficient_table_unit: done, clean");
    end else begin
      $display("tb_sorted_sparse_coefficient_table_unit: done, errors");
    end
    $finish;
  end

endmodule
